[rtl/tsm_pkg.sv]
// shared constants for the two-way sorted stream merge
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tsm_pkg;

    localparam int FIFO_DEPTH_DEF = 32;
    localparam int VALUE_BITS_DEF = 31;

endpackage

`default_nettype wire

[rtl/tsm_ram.sv]
// per-side value store: one write port, one registered read port
// depends on tsm_pkg for default sizes
`timescale 1ns / 1ps
`default_nettype none

module tsm_ram #(
    parameter int DEPTH = tsm_pkg::FIFO_DEPTH_DEF,
    parameter int WIDTH = tsm_pkg::VALUE_BITS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);
    import tsm_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/two_way_sorted_stream_merge.sv]
// Two-way merge of ascending streams, one FIFO memory per side.
// An item that releases no result, or a dropped push, returns the block to idle for the next item;
// an item that releases merge results goes through S_FETCH to S_PICK, which loads one
// result per cycle unless the output stalls; the input stalls until the block is idle.
// A dropped push is flagged in the cycle after its transfer; output stalls delay results.
// Reset (synchronous, active low) clears counts, pointers, end flags and control.
`timescale 1ns / 1ps
`default_nettype none

module two_way_sorted_stream_merge #(
    parameter int FIFO_DEPTH = tsm_pkg::FIFO_DEPTH_DEF,
    parameter int VALUE_BITS = tsm_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_side,
    input  wire logic [VALUE_BITS-1:0] i_sample,
    input  wire logic                  i_end_mark,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [VALUE_BITS-1:0] o_merged,
    output logic                       o_end_of_data,
    output logic                       o_overflow,
    output logic                       o_last
);
    import tsm_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_PICK  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt0, n_cnt0, r_cnt1, n_cnt1;
    logic [PTR_W-1:0] r_head0, n_head0, r_head1, n_head1;
    logic [PTR_W-1:0] r_tail0, n_tail0, r_tail1, n_tail1;
    logic r_end0, n_end0, r_end1, n_end1;

    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_merged, n_out_merged;
    logic                  r_out_eod, n_out_eod;
    logic                  r_out_ovf, n_out_ovf;
    logic                  r_out_last, n_out_last;
    logic                  load_out;

    logic                  we0, we1;
    logic [VALUE_BITS-1:0] rdata0, rdata1;
    logic                  out_free;
    logic                  in_take;
    logic                  side_ended, side_full;
    logic                  both_have, take0, pop0, pop1, fin;

    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // whether the merge can produce a result from this state
    function automatic logic has_work(input logic [CNT_W-1:0] c0, input logic [CNT_W-1:0] c1,
                                      input logic e0, input logic e1);
        logic ne0, ne1;
        ne0 = (c0 != '0);
        ne1 = (c1 != '0);
        return (ne0 && ne1) || (ne0 && e1) || (ne1 && e0) || (e0 && e1 && !ne0 && !ne1);
    endfunction

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_take    = i_in_valid && !o_in_stall;

    tsm_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(VALUE_BITS), .ADDR_W(PTR_W)) u_ram0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (r_tail0),
        .i_wdata (i_sample),
        .i_raddr (n_head0),
        .o_rdata (rdata0)
    );

    tsm_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(VALUE_BITS), .ADDR_W(PTR_W)) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (r_tail1),
        .i_wdata (i_sample),
        .i_raddr (n_head1),
        .o_rdata (rdata1)
    );

    always_comb begin
        n_state      = r_state;
        n_cnt0       = r_cnt0;
        n_cnt1       = r_cnt1;
        n_head0      = r_head0;
        n_head1      = r_head1;
        n_tail0      = r_tail0;
        n_tail1      = r_tail1;
        n_end0       = r_end0;
        n_end1       = r_end1;
        we0          = 1'b0;
        we1          = 1'b0;
        load_out     = 1'b0;
        n_out_merged = '0;
        n_out_eod    = 1'b0;
        n_out_ovf    = 1'b0;
        n_out_last   = 1'b0;
        side_ended   = i_side ? r_end1 : r_end0;
        side_full    = i_side ? (r_cnt1 == CNT_W'(FIFO_DEPTH)) : (r_cnt0 == CNT_W'(FIFO_DEPTH));
        both_have    = (r_cnt0 != '0) && (r_cnt1 != '0);
        take0        = rdata0 < rdata1;
        pop0         = both_have ? take0 : ((r_cnt0 != '0) && r_end1);
        pop1         = both_have ? !take0 : ((r_cnt1 != '0) && r_end0);
        fin          = r_end0 && r_end1 && (r_cnt0 == '0) && (r_cnt1 == '0);

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (i_end_mark) begin
                        if (i_side) begin
                            n_end1 = 1'b1;
                        end else begin
                            n_end0 = 1'b1;
                        end
                    end else if (side_ended || side_full) begin
                        // dropped push: single flagged transfer
                        load_out   = 1'b1;
                        n_out_ovf  = 1'b1;
                        n_out_last = 1'b1;
                    end else if (i_side) begin
                        we1     = 1'b1;
                        n_tail1 = ptr_adv(r_tail1);
                        n_cnt1  = r_cnt1 + 1'b1;
                    end else begin
                        we0     = 1'b1;
                        n_tail0 = ptr_adv(r_tail0);
                        n_cnt0  = r_cnt0 + 1'b1;
                    end
                    if (!load_out && has_work(n_cnt0, n_cnt1, n_end0, n_end1)) begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                if (out_free) begin
                    if (pop0) begin
                        load_out     = 1'b1;
                        n_out_merged = rdata0;
                        n_head0      = ptr_adv(r_head0);
                        n_cnt0       = r_cnt0 - 1'b1;
                    end else if (pop1) begin
                        load_out     = 1'b1;
                        n_out_merged = rdata1;
                        n_head1      = ptr_adv(r_head1);
                        n_cnt1       = r_cnt1 - 1'b1;
                    end else if (fin) begin
                        load_out  = 1'b1;
                        n_out_eod = 1'b1;
                        n_end0    = 1'b0;
                        n_end1    = 1'b0;
                        n_head0   = '0;
                        n_head1   = '0;
                        n_tail0   = '0;
                        n_tail1   = '0;
                    end
                    // next result exists or not depends on counts and flags only
                    n_out_last = fin || !has_work(n_cnt0, n_cnt1, n_end0, n_end1);
                    n_state    = (load_out && !n_out_last) ? S_PICK : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt0      <= '0;
            r_cnt1      <= '0;
            r_head0     <= '0;
            r_head1     <= '0;
            r_tail0     <= '0;
            r_tail1     <= '0;
            r_end0      <= 1'b0;
            r_end1      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt0  <= n_cnt0;
            r_cnt1  <= n_cnt1;
            r_head0 <= n_head0;
            r_head1 <= n_head1;
            r_tail0 <= n_tail0;
            r_tail1 <= n_tail1;
            r_end0  <= n_end0;
            r_end1  <= n_end1;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_merged <= n_out_merged;
            r_out_eod    <= n_out_eod;
            r_out_ovf    <= n_out_ovf;
            r_out_last   <= n_out_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_merged      = r_out_merged;
    assign o_end_of_data = r_out_eod;
    assign o_overflow    = r_out_ovf;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire
